[hw/rtl/fbfq_pkg.sv]
// Shared types, sizes and codes for the frame buffer flip queue.
// No dependencies; imported by every module of the block.
package fbfq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [2:0]        action_t;
    typedef logic [1:0]        kind_t;

    localparam action_t ACT_FLIP        = 3'd0;
    localparam action_t ACT_FLIP_RESYNC = 3'd1;
    localparam action_t ACT_RELEASE     = 3'd2;
    localparam action_t ACT_END_FRAME   = 3'd3;
    localparam action_t ACT_DRAIN       = 3'd4;
    localparam action_t ACT_READ_FREE   = 3'd5;
    localparam action_t ACT_CLEAR_ALL   = 3'd6;

    localparam kind_t KIND_DONE = 2'd0;
    localparam kind_t KIND_SCAN = 2'd1;
    localparam kind_t KIND_SLOT = 2'd2;

    localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);
    localparam cnt_t LAST_SLOT = cnt_t'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } list_cmd_t;

endpackage

[hw/rtl/frame_buffer_flip_queue.sv]
// Top level: sequencer and shared slot comparator over the pending queue
// and free list. Depends on fbfq_pkg and fbfq_list.
//
//  channel | signals                                             | dir
//  item    | item_valid item_ready action buffer_address         | in
//  result  | result_valid result_ready result_kind address       | out
//          | dropped last                                        |
//
// The shared comparator makes one slot compare per cycle while a list is scanned.
// flip / release: scan and append to the target list; end_of_frame: promote one entry.
// drain: promote until the pending queue is empty; flip_resync: a flip, then a drain.
// read_free: one beat per free-list slot, held by any result stalls.
// Reset clears all slots, on-screen address and sequencer at once.
// A stalled result holds the sequencer only when it has a new beat to load.
module frame_buffer_flip_queue
    import fbfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  action_t action,
    input  addr_t   buffer_address,
    output logic    result_valid,
    input  logic    result_ready,
    output kind_t   result_kind,
    output addr_t   address,
    output logic    dropped,
    output logic    last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_PROMOTE,
        ST_EMIT_DONE,
        ST_EMIT_SCAN,
        ST_EMIT_SLOT
    } state_t;

    state_t    state_reg;
    action_t   op_reg;
    logic      tgt_fl_reg;
    addr_t     val_reg;
    cnt_t      idx_reg;
    logic      drop_reg;
    addr_t     on_screen_reg;

    logic      out_valid_reg;
    kind_t     out_kind_reg;
    addr_t     out_addr_reg;
    logic      out_drop_reg;
    logic      out_last_reg;

    list_cmd_t pq_cmd, fl_cmd;
    addr_t     pq_rd, fl_rd, pq_head, fl_head;
    cnt_t      pq_cnt, fl_cnt;

    addr_t     sel_rd;
    cnt_t      sel_cnt;
    logic      hit;
    logic      at_end;
    logic      accept;
    logic      out_free;
    logic      out_load;
    logic      put_zero;
    logic      put_push;
    logic      put_done;
    logic      slot_last;
    state_t    after_put;

    fbfq_list u_pq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pq_cmd),
        .push_data (val_reg),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_data   (pq_rd),
        .head      (pq_head),
        .count     (pq_cnt)
    );

    fbfq_list u_fl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fl_cmd),
        .push_data (val_reg),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_data   (fl_rd),
        .head      (fl_head),
        .count     (fl_cnt)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;
    assign out_load   = out_free && (state_reg == ST_EMIT_DONE || state_reg == ST_EMIT_SCAN
                                     || state_reg == ST_EMIT_SLOT);

    // shared compare unit
    assign sel_rd    = tgt_fl_reg ? fl_rd : pq_rd;
    assign sel_cnt   = tgt_fl_reg ? fl_cnt : pq_cnt;
    assign hit       = (sel_rd == val_reg);
    assign at_end    = (idx_reg == sel_cnt);
    assign put_zero  = (val_reg == '0);
    assign put_push  = !put_zero && at_end && (sel_cnt != DEPTH_CNT);
    assign put_done  = put_zero || at_end || hit;
    assign slot_last = (idx_reg == LAST_SLOT);

    always_comb
    begin
        if (!tgt_fl_reg)
        begin
            after_put = (op_reg == ACT_FLIP_RESYNC) ? ST_PROMOTE : ST_EMIT_DONE;
        end
        else if (op_reg == ACT_RELEASE)
        begin
            after_put = ST_EMIT_DONE;
        end
        else if (op_reg == ACT_END_FRAME)
        begin
            after_put = ST_EMIT_SCAN;
        end
        else
        begin
            after_put = ST_PROMOTE;
        end
    end

    always_comb
    begin
        pq_cmd = '0;
        fl_cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pq_cmd.clear = accept && (action == ACT_CLEAR_ALL);
                fl_cmd.clear = accept && (action == ACT_CLEAR_ALL);
            end
            ST_PUT:
            begin
                pq_cmd.push = put_push && !tgt_fl_reg;
                fl_cmd.push = put_push && tgt_fl_reg;
            end
            ST_PROMOTE:
            begin
                pq_cmd.pop = 1'b1;
            end
            ST_EMIT_SLOT:
            begin
                fl_cmd.clear = out_free && slot_last;
            end
            default:
            begin
                pq_cmd = '0;
                fl_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= ACT_FLIP;
            tgt_fl_reg    <= 1'b0;
            val_reg       <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            on_screen_reg <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_DONE;
            out_addr_reg  <= '0;
            out_drop_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (result_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= action;
                        drop_reg <= 1'b0;
                        idx_reg  <= '0;
                        val_reg  <= buffer_address;
                        unique case (action)
                            ACT_FLIP, ACT_FLIP_RESYNC:
                            begin
                                tgt_fl_reg <= 1'b0;
                                state_reg  <= ST_PUT;
                            end
                            ACT_RELEASE:
                            begin
                                tgt_fl_reg <= 1'b1;
                                state_reg  <= ST_PUT;
                            end
                            ACT_END_FRAME, ACT_DRAIN:
                            begin
                                state_reg <= ST_PROMOTE;
                            end
                            ACT_READ_FREE:
                            begin
                                state_reg <= ST_EMIT_SLOT;
                            end
                            ACT_CLEAR_ALL:
                            begin
                                on_screen_reg <= '0;
                                state_reg     <= ST_EMIT_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT_DONE;
                            end
                        endcase
                    end
                end
                ST_PUT:
                begin
                    if (!put_zero && at_end && sel_cnt == DEPTH_CNT)
                    begin
                        drop_reg <= 1'b1;
                    end
                    if (put_done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= after_put;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + cnt_t'(1);
                    end
                end
                ST_PROMOTE:
                begin
                    if (pq_head != '0)
                    begin
                        val_reg       <= on_screen_reg;
                        on_screen_reg <= pq_head;
                        tgt_fl_reg    <= 1'b1;
                        idx_reg       <= '0;
                        state_reg     <= ST_PUT;
                    end
                    else
                    begin
                        state_reg <= (op_reg == ACT_END_FRAME) ? ST_EMIT_SCAN : ST_EMIT_DONE;
                    end
                end
                ST_EMIT_DONE, ST_EMIT_SCAN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= (state_reg == ST_EMIT_SCAN) ? KIND_SCAN : KIND_DONE;
                        out_addr_reg  <= (state_reg == ST_EMIT_SCAN) ? pq_head : '0;
                        out_drop_reg  <= drop_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_EMIT_SLOT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_SLOT;
                        out_addr_reg  <= fl_rd;
                        out_drop_reg  <= 1'b0;
                        out_last_reg  <= slot_last;
                        if (slot_last)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + cnt_t'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign address      = out_addr_reg;
    assign dropped      = out_drop_reg;
    assign last         = out_last_reg;

endmodule

[hw/rtl/fbfq_list.sv]
// Packed address list: append at the fill count, shift out at slot 0, clear.
// Depends on fbfq_pkg.
module fbfq_list
    import fbfq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  list_cmd_t cmd,
    input  addr_t     push_data,
    input  idx_t      rd_idx,
    output addr_t     rd_data,
    output addr_t     head,
    output cnt_t      count
);

    addr_t slot_reg [QUEUE_DEPTH];
    cnt_t  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
            slot_reg[QUEUE_DEPTH-1] <= '0;
            if (count_reg != '0)
            begin
                count_reg <= count_reg - cnt_t'(1);
            end
        end
        else if (cmd.push && count_reg != DEPTH_CNT)
        begin
            slot_reg[count_reg[IDX_W-1:0]] <= push_data;
            count_reg <= count_reg + cnt_t'(1);
        end
    end

    assign rd_data = slot_reg[rd_idx];
    assign head    = slot_reg[0];
    assign count   = count_reg;

endmodule

[hw/rtl/fbfq_checker.sv]
// Port-level checks for frame_buffer_flip_queue, bound to the top level.
// Depends on fbfq_pkg.
module fbfq_checker
    import fbfq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input action_t action,
    input addr_t   buffer_address,
    input logic    result_valid,
    input logic    result_ready,
    input kind_t   result_kind,
    input addr_t   address,
    input logic    dropped,
    input logic    last
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(address)
            && $stable(result_kind) && $stable(last))
        else $error("result beat changed while stalled");

    // an accepted item leaves the sequencer busy, so items are never accepted back to back
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted back to back");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_DONE |-> last && address == '0)
        else $error("done beat not final or address nonzero");

    a_slot_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_SLOT || result_kind == KIND_SCAN
            || result_kind == KIND_DONE) |-> !(result_kind == KIND_SLOT && dropped))
        else $error("free-list slot beat flagged dropped");

endmodule

bind frame_buffer_flip_queue fbfq_checker u_fbfq_checker (.*);
